// File: rtl/rtxp_pkg.sv
// rtxp_pkg: shared types and constants for the radix text parser.
// Holds the span phase enum, status codes, register map, digit script table
// and the structs passed between the parser modules. No dependencies.
`timescale 1ns / 1ps

package rtxp_pkg;

  // Span length cap; position and stop counters saturate here.
  localparam int MAX_LEN = 4096;
  localparam int POS_W   = $clog2(MAX_LEN + 1);

  localparam int CHAR_W  = 21;
  localparam int VALUE_W = 64;
  localparam int HALF_W  = 32;
  localparam int STOP_W  = 13;
  localparam int RADIX_W = 6;
  localparam int DIG_W   = 6;
  localparam int PROD_W  = VALUE_W + RADIX_W + 1;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] BASE_OCT    = RADIX_W'(8);
  localparam logic [RADIX_W-1:0] BASE_DEC    = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] BASE_HEX    = RADIX_W'(16);
  localparam logic [RADIX_W-1:0] BASE_AUTO   = RADIX_W'(0);
  localparam logic [RADIX_W-1:0] BASE_UNARY  = RADIX_W'(1);
  localparam logic [RADIX_W-1:0] BASE_MIN    = RADIX_W'(2);

  // Register index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_RADIX  = 2'd0,
    REG_SIGNED = 2'd1,
    REG_WIDE   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_WS       = 3'd0,
    PH_START    = 3'd1,
    PH_ZERO     = 3'd2,
    PH_DIGITS   = 3'd3,
    PH_STOPPED  = 3'd4,
    PH_REJECTED = 3'd5,
    PH_BADBASE  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_DIGIT = 2'd1,
    ST_RANGE    = 2'd2,
    ST_MINUS    = 2'd3
  } status_t;

  // Code points of digit zero in each supported script (last: fullwidth).
  localparam int NUM_SCRIPTS = 18;
  localparam logic [CHAR_W-1:0] SCRIPT_ZERO [NUM_SCRIPTS] = '{
    21'h00030, 21'h00660, 21'h006F0, 21'h00966, 21'h009E6, 21'h00A66,
    21'h00AE6, 21'h00B66, 21'h00C66, 21'h00CE6, 21'h00D66, 21'h00E50,
    21'h00ED0, 21'h00F20, 21'h01040, 21'h017E0, 21'h01810, 21'h0FF10
  };

  localparam logic [CHAR_W-1:0] CH_TAB   = 21'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 21'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 21'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 21'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 21'h2D;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 21'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 21'h5A;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 21'h58;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 21'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 21'h7A;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 21'h78;

  typedef struct packed {
    logic             is_space;
    logic             is_minus;
    logic             is_plus;
    logic             is_hex_x;
    logic             is_zero;   // script digit zero (any script)
    logic             dig_ok;    // digit or letter
    logic [DIG_W-1:0] dig_val;
  } char_class_t;

  // Span snapshot handed to the result formatter.
  typedef struct packed {
    logic               rejected;
    logic               no_digits;
    logic               negative;
    logic               overflowed;
    logic               signed_mode;
    logic               wide_mode;
    logic [VALUE_W-1:0] accum;
    logic [POS_W-1:0]   stop;
  } span_fin_t;

endpackage

// File: rtl/rtxp_char_class.sv
// rtxp_char_class: classifies one code point (space, sign, hex x, digit value).
// Depends on rtxp_pkg for the script table and the char_class_t struct.
`timescale 1ns / 1ps

module rtxp_char_class
  import rtxp_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  output char_class_t       cls
);

  function automatic logic [4:0] script_digit(input logic [CHAR_W-1:0] c);
    logic [4:0]        res;
    logic [CHAR_W-1:0] diff;
    res = 5'h10;  // bit 4 set: no match
    for (int i = 0; i < NUM_SCRIPTS; i++) begin
      diff = c - SCRIPT_ZERO[i];
      if (c >= SCRIPT_ZERO[i] && diff < CHAR_W'(10)) begin
        res = {1'b0, diff[3:0]};
      end
    end
    return res;
  endfunction

  logic [4:0]        sd;
  logic [CHAR_W-1:0] up_off;
  logic [CHAR_W-1:0] lo_off;

  assign sd     = script_digit(char_code);
  assign up_off = char_code - CH_UP_A + CHAR_W'(10);
  assign lo_off = char_code - CH_LO_A + CHAR_W'(10);

  always_comb begin
    cls.is_space = (char_code == CH_SPACE) ||
                   (char_code >= CH_TAB && char_code <= CH_CR);
    cls.is_minus = (char_code == CH_MINUS);
    cls.is_plus  = (char_code == CH_PLUS);
    cls.is_hex_x = (char_code == CH_LO_X) || (char_code == CH_UP_X);
    cls.is_zero  = (sd == 5'd0);
    if (!sd[4]) begin
      cls.dig_ok  = 1'b1;
      cls.dig_val = DIG_W'(sd[3:0]);
    end else if (char_code >= CH_UP_A && char_code <= CH_UP_Z) begin
      cls.dig_ok  = 1'b1;
      cls.dig_val = up_off[DIG_W-1:0];
    end else if (char_code >= CH_LO_A && char_code <= CH_LO_Z) begin
      cls.dig_ok  = 1'b1;
      cls.dig_val = lo_off[DIG_W-1:0];
    end else begin
      cls.dig_ok  = 1'b0;
      cls.dig_val = '0;
    end
  end

endmodule

// File: rtl/rtxp_result_fmt.sv
// rtxp_result_fmt: turns a finished span snapshot into value, stop and status.
// Depends on rtxp_pkg for span_fin_t and status codes; purely combinational.
`timescale 1ns / 1ps

module rtxp_result_fmt
  import rtxp_pkg::*;
(
  input  span_fin_t          fin,
  output logic [VALUE_W-1:0] value_bits,
  output logic [STOP_W-1:0]  stop_offset,
  output status_t            status
);

  logic [VALUE_W-1:0] lim;
  logic [VALUE_W-1:0] half;
  logic [VALUE_W-1:0] sat;
  logic [VALUE_W-1:0] mag;
  logic [VALUE_W-1:0] sval;
  logic               oor;

  always_comb begin
    lim  = fin.wide_mode ? '1 : {{(VALUE_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};
    half = fin.wide_mode ? {1'b1, {(VALUE_W-1){1'b0}}}
                         : VALUE_W'({1'b1, {(HALF_W-1){1'b0}}});

    oor = fin.overflowed || (!fin.wide_mode && (|fin.accum[VALUE_W-1:HALF_W]));
    if (fin.signed_mode) begin
      if (fin.negative) oor = oor || (fin.accum > half);
      else              oor = oor || (fin.accum >= half);
    end

    if (!fin.signed_mode)  sat = lim;
    else if (fin.negative) sat = half;
    else                   sat = half - VALUE_W'(1);

    mag  = oor ? sat : fin.accum;
    sval = fin.negative ? (~mag + VALUE_W'(1)) : mag;
    if (!fin.wide_mode) begin
      sval = {{(VALUE_W-HALF_W){fin.signed_mode & sval[HALF_W-1]}}, sval[HALF_W-1:0]};
    end

    if (fin.rejected) begin
      status      = ST_MINUS;
      value_bits  = '0;
      stop_offset = '0;
    end else if (fin.no_digits) begin
      status      = ST_NO_DIGIT;
      value_bits  = '0;
      stop_offset = '0;
    end else begin
      status      = oor ? ST_RANGE : ST_OK;
      value_bits  = sval;
      stop_offset = STOP_W'(fin.stop);
    end
  end

endmodule

// File: rtl/radix_integer_text_parser_unit.sv
// radix_integer_text_parser_unit: streaming string-to-integer parser, top level.
// Depends on rtxp_pkg, rtxp_char_class and rtxp_result_fmt.
// Throughput: one character request per cycle while char_stall is low; span state updates
// in one pass. A result passes through the span snapshot register, then the result
// register; characters of the next span may follow at once.
// Reset (rst, synchronous): radix 10, signed and wide mode on, span state cleared, no result.
`timescale 1ns / 1ps

module radix_integer_text_parser_unit
  import rtxp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  // APB-style configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,

  // character request channel
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic               last_char,

  // result request channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic [VALUE_W-1:0] value_bits,
  output logic [STOP_W-1:0]  stop_offset,
  output logic [1:0]         status
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [RADIX_W-1:0] radix;
  logic               signed_mode;
  logic               wide_mode;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_RESET;
      signed_mode <= 1'b1;
      wide_mode   <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RADIX:  radix       <= pwdata[RADIX_W-1:0];
        REG_SIGNED: signed_mode <= pwdata[0];
        REG_WIDE:   wide_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RADIX:  prdata = DATA_W'(radix);
      REG_SIGNED: prdata = DATA_W'(signed_mode);
      REG_WIDE:   prdata = DATA_W'(wide_mode);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: snapshot register + result register form a two-entry path.
  // Only a last character needs the snapshot slot, so ordinary characters
  // keep flowing while a result waits downstream.
  // ---------------------------------------------------------------------------
  logic      fin_valid;
  span_fin_t fin;
  span_fin_t fin_next;
  logic      fin_move;
  logic      char_fire;
  logic      span_end;

  assign fin_move   = fin_valid && (!result_valid || !result_stall);
  assign char_stall = last_char && fin_valid && !fin_move;
  assign char_fire  = char_valid && !char_stall;
  assign span_end   = char_fire && last_char;

  // ---------------------------------------------------------------------------
  // Span state
  // ---------------------------------------------------------------------------
  phase_t             phase, phase_next, phase_eff;
  logic [VALUE_W-1:0] accum, accum_next;
  logic [RADIX_W-1:0] base_in_use, base_in_use_next, base_eff;
  logic               negative, negative_next;
  logic               overflowed, overflowed_next;
  logic               got_digit, got_digit_next;
  logic [POS_W-1:0]   position, position_next;
  logic [POS_W-1:0]   stop_pos, stop_pos_next;

  char_class_t cls;

  rtxp_char_class u_class (
    .char_code (char_code),
    .cls       (cls)
  );

  // Radix is latched on the first character of a span; a unary or too-large
  // radix poisons the whole span.
  logic span_first;
  logic bad_radix;

  assign span_first = (position == '0) && (phase == PH_WS);
  assign bad_radix  = (radix == BASE_UNARY) || (radix > RADIX_MAX);
  assign base_eff   = span_first ? radix : base_in_use;
  assign phase_eff  = (span_first && bad_radix) ? PH_BADBASE : phase;

  // Decode which path this character takes
  logic               ws_ph;
  logic               start_path;
  logic               zero_hit;
  logic               zero_take;
  logic               hex_pfx;
  logic               take_now;
  logic [RADIX_W-1:0] start_base;
  logic [RADIX_W-1:0] zero_base;
  logic [RADIX_W-1:0] take_base;
  logic               digit_ok;
  logic [PROD_W-1:0]  prod;
  logic               fits;
  logic [POS_W-1:0]   pos_inc;

  assign ws_ph      = (phase_eff == PH_WS);
  assign start_path = (ws_ph && !cls.is_space && !cls.is_minus && !cls.is_plus) ||
                      (phase_eff == PH_START);
  // leading zero under auto or hex base: maybe a 0x prefix follows
  assign zero_hit   = start_path && cls.is_zero &&
                      ((base_eff == BASE_AUTO) || (base_eff == BASE_HEX));
  assign hex_pfx    = (phase_eff == PH_ZERO) && cls.is_hex_x;
  assign zero_take  = (phase_eff == PH_ZERO) && !cls.is_hex_x;
  assign take_now   = (start_path && !zero_hit) || zero_take || (phase_eff == PH_DIGITS);

  assign start_base = (base_eff == BASE_AUTO) ? BASE_DEC : base_eff;
  assign zero_base  = (base_eff == BASE_AUTO) ? BASE_OCT : base_eff;
  assign take_base  = start_path ? start_base :
                      (phase_eff == PH_ZERO) ? zero_base : base_eff;

  assign digit_ok = cls.dig_ok && (cls.dig_val < take_base) && (take_base >= BASE_MIN);

  // accum * base + digit fits the limit exactly when no overflow would occur
  assign prod = PROD_W'(accum) * PROD_W'(take_base) + PROD_W'(cls.dig_val);
  assign fits = wide_mode ? (prod[PROD_W-1:VALUE_W] == '0)
                          : (prod[PROD_W-1:HALF_W] == '0);

  assign pos_inc = (position == POS_W'(MAX_LEN)) ? position : position + POS_W'(1);

  // next phase
  always_comb begin
    case (phase_eff)
      PH_WS: begin
        if (cls.is_space)      phase_next = PH_WS;
        else if (cls.is_minus) phase_next = signed_mode ? PH_START : PH_REJECTED;
        else if (cls.is_plus)  phase_next = PH_START;
        else if (zero_hit)     phase_next = PH_ZERO;
        else                   phase_next = digit_ok ? PH_DIGITS : PH_STOPPED;
      end
      PH_START: begin
        if (zero_hit) phase_next = PH_ZERO;
        else          phase_next = digit_ok ? PH_DIGITS : PH_STOPPED;
      end
      PH_ZERO: begin
        if (cls.is_hex_x) phase_next = PH_DIGITS;
        else              phase_next = digit_ok ? PH_DIGITS : PH_STOPPED;
      end
      PH_DIGITS: phase_next = digit_ok ? PH_DIGITS : PH_STOPPED;
      default:   phase_next = phase_eff;
    endcase
  end

  // datapath next values
  always_comb begin
    if (hex_pfx)       base_in_use_next = BASE_HEX;
    else if (take_now) base_in_use_next = take_base;
    else               base_in_use_next = base_eff;

    negative_next   = negative || (ws_ph && cls.is_minus && signed_mode);
    overflowed_next = overflowed || (take_now && digit_ok && !fits);
    got_digit_next  = got_digit || zero_hit || (take_now && digit_ok);
    stop_pos_next   = (zero_hit || (take_now && digit_ok)) ? pos_inc : stop_pos;
    position_next   = pos_inc;

    if (zero_hit)                         accum_next = '0;
    else if (take_now && digit_ok && fits) accum_next = prod[VALUE_W-1:0];
    else                                  accum_next = accum;

    fin_next.rejected    = (phase_next == PH_REJECTED);
    fin_next.no_digits   = (phase_next == PH_BADBASE) || !got_digit_next;
    fin_next.negative    = negative_next;
    fin_next.overflowed  = overflowed_next;
    fin_next.signed_mode = signed_mode;
    fin_next.wide_mode   = wide_mode;
    fin_next.accum       = accum_next;
    fin_next.stop        = stop_pos_next;
  end

  always_ff @(posedge clk) begin
    if (rst || span_end) begin
      phase       <= PH_WS;
      accum       <= '0;
      base_in_use <= '0;
      negative    <= 1'b0;
      overflowed  <= 1'b0;
      got_digit   <= 1'b0;
      position    <= '0;
      stop_pos    <= '0;
    end else if (char_fire) begin
      phase       <= phase_next;
      accum       <= accum_next;
      base_in_use <= base_in_use_next;
      negative    <= negative_next;
      overflowed  <= overflowed_next;
      got_digit   <= got_digit_next;
      position    <= position_next;
      stop_pos    <= stop_pos_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Snapshot and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (span_end) begin
      fin_valid <= 1'b1;
    end else if (fin_move) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (span_end) begin
      fin <= fin_next;
    end
  end

  logic [VALUE_W-1:0] fmt_value;
  logic [STOP_W-1:0]  fmt_stop;
  status_t            fmt_status;

  rtxp_result_fmt u_fmt (
    .fin         (fin),
    .value_bits  (fmt_value),
    .stop_offset (fmt_stop),
    .status      (fmt_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      value_bits  <= fmt_value;
      stop_offset <= fmt_stop;
      status      <= fmt_status;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // a span end clears the span state for the next span
  a_span_clear: assert property (@(posedge clk) disable iff (rst)
    span_end |=> (position == '0) && (phase == PH_WS) && !got_digit && !negative)
    else $error("span state not cleared after last character");

  // a last character is only taken when the snapshot slot is free or draining
  a_fin_slot: assert property (@(posedge clk) disable iff (rst)
    span_end |-> (!fin_valid || fin_move))
    else $error("snapshot overwritten before reaching result register");

  // rejected minus and no-digit results carry zero value and zero offset
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((status == ST_MINUS) || (status == ST_NO_DIGIT)) |->
      (value_bits == '0) && (stop_offset == '0))
    else $error("failed parse with nonzero value or offset");

  // counters saturate at the span length cap
  a_pos_cap: assert property (@(posedge clk) disable iff (rst)
    (position <= POS_W'(MAX_LEN)) && (stop_pos <= position))
    else $error("position counters out of range");
`endif

endmodule
